// File: rtl/core/glex_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glex_pkg: shared definitions for the 3x3 local extrema unit
// Widths, register indexes, result record and the window classifier.
// ----------------------------------------------------------------------------
package glex_pkg;

  localparam int unsigned VAL_W      = 32;
  localparam int unsigned ROW_W      = 10;
  localparam int unsigned COL_W      = 6;
  localparam int unsigned MAX_ROWS   = 1 << ROW_W;
  localparam int unsigned MAX_COLS   = 1 << COL_W;
  localparam int unsigned ROW_CNT_W  = ROW_W + 1;
  localparam int unsigned COL_CNT_W  = COL_W + 1;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = ROW_CNT_W;
  localparam int unsigned LINE_W     = 2 * VAL_W;   // {row r-2, row r-1} per column
  localparam int unsigned RES_SLOTS  = 4;
  localparam int unsigned SLOT_W     = 2;
  localparam int unsigned ROW_CNT_RST = 20;
  localparam int unsigned COL_CNT_RST = 20;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = CFG_IDX_W'(1);

  typedef logic [VAL_W-1:0] val_t;
  typedef val_t [2:0][2:0] win_t;   // [row: 0 = r-2 .. 2 = r][col: 0 = c-2 .. 2 = c]

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             is_max;
    logic             is_min;
    logic             frame_done;
  } res_t;

  // Count register to last index; zero acts as one, overflow clamps.
  function automatic logic [ROW_W-1:0] last_row_of(logic [ROW_CNT_W-1:0] v);
    if (v == '0) begin
      return '0;
    end else if (v > ROW_CNT_W'(MAX_ROWS)) begin
      return ROW_W'(MAX_ROWS - 1);
    end
    return ROW_W'(v - 1'b1);
  endfunction

  function automatic logic [COL_W-1:0] last_col_of(logic [COL_CNT_W-1:0] v);
    if (v == '0) begin
      return '0;
    end else if (v > COL_CNT_W'(MAX_COLS)) begin
      return COL_W'(MAX_COLS - 1);
    end
    return COL_W'(v - 1'b1);
  endfunction

  // Classify the cell at window place (ci,cj) against its in-grid,
  // in-window neighbors. ci/cj are constants at every call site.
  function automatic res_t make_result(win_t w, int ci, int cj,
                                       logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                                       logic [ROW_W-1:0] last_row,
                                       logic [COL_W-1:0] last_col);
    res_t               res;
    logic               up_ok, dn_ok, lf_ok, rt_ok, in_grid;
    logic signed [VAL_W-1:0] ctr, nb;
    int                 ni, nj;
    up_ok          = (row != '0);
    dn_ok          = (row != last_row);
    lf_ok          = (col != '0);
    rt_ok          = (col != last_col);
    ctr            = $signed(w[ci[1:0]][cj[1:0]]);
    res.row        = row;
    res.col        = col;
    res.is_max     = 1'b1;
    res.is_min     = 1'b1;
    res.frame_done = (row == last_row) && (col == last_col);
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        ni      = ci + dr;
        nj      = cj + dc;
        in_grid = !(dr == -1 && !up_ok) && !(dr == 1 && !dn_ok) &&
                  !(dc == -1 && !lf_ok) && !(dc == 1 && !rt_ok);
        if ((dr != 0 || dc != 0) && ni >= 0 && ni <= 2 && nj >= 0 && nj <= 2 &&
            in_grid) begin
          nb = $signed(w[ni[1:0]][nj[1:0]]);
          if (nb > ctr) res.is_max = 1'b0;
          if (nb < ctr) res.is_min = 1'b0;
        end
      end
    end
    return res;
  endfunction

endpackage

// File: rtl/core/glex_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glex_ram: generic simple dual-port RAM
// One write port, one read port with registered read data (read-old).
// ----------------------------------------------------------------------------
module glex_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/grid_local_extrema_3x3_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_local_extrema_3x3_unit: streaming 3x3 local max/min classifier
// Line-store RAM plus 3x3 window; every cell reported once, in raster order except that the last two rows interleave.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats carry one signed grid value each, in raster order. Each cell
//   is reported as soon as its last in-grid neighbor has arrived, with its
//   row, column, max/min flags, last_of_run (final result of the input beat)
//   and frame_done (grid's final cell). After the final cell the position
//   wraps and the next beat starts a new frame.
//   Config writes (row_count, col_count) restart the frame; issue them only
//   while the unit is idle. cfg_ready_o is always high.
// Timing:
//   A beat with results holds stage 1 until the result group is free; the group
//   drains one result per cycle through the output register while out_stall_i
//   is low. Most beats cause at most one and, unstalled, run back to back;
//   beats in the last column or last row can cause two, the grid's final beat four.
//   Results pass from stage 1 through the result group to the output register.
//   Line store: one RAM word per column, read at accept, written back as
//   stage 1 fires; a one-column grid is served by a forwarding register.
// Reset: position and pipeline cleared, sizes back to 20 x 20; no RAM sweep,
//   stale line-store words only ever feed out-of-grid neighbors.
// Stall: out_stall_i holds the result register; backpressure reaches
//   in_stall_o within the same cycle once a beat with results meets a busy group.
// ----------------------------------------------------------------------------
module grid_local_extrema_3x3_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [glex_pkg::VAL_W-1:0] cell_value_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [glex_pkg::ROW_W-1:0]     cell_row_o,
  output logic [glex_pkg::COL_W-1:0]     cell_col_o,
  output logic                           is_maximum_o,
  output logic                           is_minimum_o,
  output logic                           last_of_run_o,
  output logic                           frame_done_o,
  // config write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [glex_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [glex_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  import glex_pkg::*;

  // --------------------------------------------------------------------------
  // Config and input position
  // --------------------------------------------------------------------------
  logic [ROW_W-1:0] last_row_q;
  logic [COL_W-1:0] last_col_q;
  logic [ROW_W-1:0] in_row_q;
  logic [COL_W-1:0] in_col_q;
  logic             cfg_we;
  logic             in_accept;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign in_accept   = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_row_q <= ROW_W'(ROW_CNT_RST - 1);
      last_col_q <= COL_W'(COL_CNT_RST - 1);
      in_row_q   <= '0;
      in_col_q   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        REG_ROW_COUNT: begin
          last_row_q <= last_row_of(cfg_data_i[ROW_CNT_W-1:0]);
          in_row_q   <= '0;
          in_col_q   <= '0;
        end
        REG_COL_COUNT: begin
          last_col_q <= last_col_of(cfg_data_i[COL_CNT_W-1:0]);
          in_row_q   <= '0;
          in_col_q   <= '0;
        end
        default: ;  // unmapped index: ignored
      endcase
    end else if (in_accept) begin
      if (in_col_q == last_col_q) begin
        in_col_q <= '0;
        in_row_q <= (in_row_q == last_row_q) ? '0 : in_row_q + 1'b1;
      end else begin
        in_col_q <= in_col_q + 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: line-store read data arrives; window update and classification
  // --------------------------------------------------------------------------
  logic                 s1_valid_q;
  logic [VAL_W-1:0]     s1_val_q;
  logic [ROW_W-1:0]     s1_row_q;
  logic [COL_W-1:0]     s1_col_q;
  logic                 fwd_hit_q;
  logic [LINE_W-1:0]    fwd_data_q;
  logic                 s1_fire;

  logic [LINE_W-1:0]    ram_rdata;
  logic [LINE_W-1:0]    line_word;
  logic [LINE_W-1:0]    wr_word;
  logic [VAL_W-1:0]     top_val, mid_val;
  win_t                 win_q, win_d;

  glex_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_COLS)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_fire),
    .waddr_i (s1_col_q),
    .wdata_i (wr_word),
    .re_i    (in_accept),
    .raddr_i (in_col_q),
    .rdata_o (ram_rdata)
  );

  // Write of the previous beat can land on the same edge as this read.
  assign line_word = fwd_hit_q ? fwd_data_q : ram_rdata;
  assign top_val   = line_word[LINE_W-1:VAL_W];
  assign mid_val   = line_word[VAL_W-1:0];
  assign wr_word   = {mid_val, s1_val_q};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_d[i][0] = win_q[i][1];
      win_d[i][1] = win_q[i][2];
    end
    win_d[0][2] = top_val;
    win_d[1][2] = mid_val;
    win_d[2][2] = s1_val_q;
  end

  // Candidate cells: (r-1,c-1), (r-1,c), (r,c-1), (r,c)
  logic [ROW_W-1:0]     s1_row_m1;
  logic [COL_W-1:0]     s1_col_m1;
  logic                 r_nz, c_nz, r_last, c_last;
  logic [RES_SLOTS-1:0] cand_mask;
  res_t                 cand [RES_SLOTS];

  assign s1_row_m1 = s1_row_q - 1'b1;
  assign s1_col_m1 = s1_col_q - 1'b1;
  assign r_nz      = (s1_row_q != '0);
  assign c_nz      = (s1_col_q != '0);
  assign r_last    = (s1_row_q == last_row_q);
  assign c_last    = (s1_col_q == last_col_q);

  assign cand_mask = {r_last && c_last, r_last && c_nz, r_nz && c_last, r_nz && c_nz};

  always_comb begin
    cand[0] = make_result(win_d, 1, 1, s1_row_m1, s1_col_m1, last_row_q, last_col_q);
    cand[1] = make_result(win_d, 1, 2, s1_row_m1, s1_col_q,  last_row_q, last_col_q);
    cand[2] = make_result(win_d, 2, 1, s1_row_q,  s1_col_m1, last_row_q, last_col_q);
    cand[3] = make_result(win_d, 2, 2, s1_row_q,  s1_col_q,  last_row_q, last_col_q);
  end

  // --------------------------------------------------------------------------
  // Result group (up to four per beat) and output register
  // --------------------------------------------------------------------------
  logic [RES_SLOTS-1:0] grp_mask_q;
  res_t                 grp_q [RES_SLOTS];
  logic [SLOT_W-1:0]    grp_head;
  logic [RES_SLOTS-1:0] grp_rest;
  logic                 grp_pop, grp_load, grp_free;
  logic                 out_free;
  logic                 out_valid_q;
  res_t                 out_res_q;
  logic                 out_last_q;

  always_comb begin
    grp_head = '0;
    for (int i = RES_SLOTS - 1; i >= 0; i--) begin
      if (grp_mask_q[i]) grp_head = SLOT_W'(i);
    end
  end

  assign grp_rest   = grp_mask_q & ~(RES_SLOTS'(1) << grp_head);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign grp_pop    = (grp_mask_q != '0) && out_free;
  assign grp_free   = (grp_mask_q == '0) || (grp_pop && grp_rest == '0);
  assign s1_fire    = s1_valid_q && (cand_mask == '0 || grp_free);
  assign grp_load   = s1_fire && (cand_mask != '0);
  assign in_stall_o = s1_valid_q && !s1_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      grp_mask_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (grp_load) begin
        grp_mask_q <= cand_mask;
      end else if (grp_pop) begin
        grp_mask_q <= grp_rest;
      end
      if (out_free) begin
        out_valid_q <= grp_pop;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_val_q   <= cell_value_i;
      s1_row_q   <= in_row_q;
      s1_col_q   <= in_col_q;
      fwd_hit_q  <= s1_fire && (s1_col_q == in_col_q);
      fwd_data_q <= wr_word;
    end
    if (s1_fire) begin
      win_q <= win_d;
    end
    if (grp_load) begin
      for (int i = 0; i < RES_SLOTS; i++) begin
        grp_q[i] <= cand[i];
      end
    end
    if (grp_pop) begin
      out_res_q  <= grp_q[grp_head];
      out_last_q <= (grp_rest == '0);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign cell_row_o    = out_res_q.row;
  assign cell_col_o    = out_res_q.col;
  assign is_maximum_o  = out_res_q.is_max;
  assign is_minimum_o  = out_res_q.is_min;
  assign last_of_run_o = out_last_q;
  assign frame_done_o  = out_res_q.frame_done;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // Grid's final cell always closes its beat's run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_done_o |-> last_of_run_o)
    else $error("frame_done without last_of_run");

  // Same-word forwarding only arises for a one-column grid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && fwd_hit_q |-> last_col_q == '0)
    else $error("line-store forward hit with more than one column");

  // A pending result is presented on the next cycle once the output frees.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    grp_mask_q != '0 && out_free |=> out_valid_o)
    else $error("result group did not drain");

  // A stage-1 beat with results never fires over a busy group.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    grp_load |-> grp_free)
    else $error("result group overwritten");

endmodule
